### sv/lcp_pkg.sv
`default_nettype none

package lcp_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int SYMBOL_BITS = 8;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SA_W        = 10;
  localparam int LCP_W       = 10;
  localparam int LCP_MAX     = (1 << LCP_W) - 1;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  // build engine -> shared memories
  typedef struct packed {
    logic                   sfx_re;
    logic [ADDR_W-1:0]      sfx_ra;
    logic                   txt_re;
    logic [ADDR_W-1:0]      txt_ra0;
    logic [ADDR_W-1:0]      txt_ra1;
    logic                   lcp_we;
    logic [ADDR_W-1:0]      lcp_wa;
    logic [LCP_W-1:0]       lcp_wd;
  } bld_req_t;

  // shared memories -> build engine
  typedef struct packed {
    logic [SA_W-1:0]        sfx_rd;
    logic [SYMBOL_BITS-1:0] txt_rd0;
    logic [SYMBOL_BITS-1:0] txt_rd1;
  } bld_rsp_t;

endpackage

`default_nettype wire

### sv/lcp_ram.sv
`default_nettype none

// 1W1R synchronous RAM, registered read
module lcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/lcp_build.sv
`default_nettype none

// Clear sweep, inverse rank pass and Kasai walk over the stored set.
module lcp_build (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [lcp_pkg::CNT_W-1:0] count_i,
  output logic                          busy_o,
  output lcp_pkg::bld_req_t             req_o,
  input  wire lcp_pkg::bld_rsp_t        rsp_i
);

  import lcp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RANK,
    W_RANK,
    W_SFX,
    W_PREV,
    W_CMP,
    W_CHK
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pidx_q, pidx_d;
  logic [ADDR_W-1:0] r_q, r_d;
  logic [SA_W-1:0]   prev_q, prev_d;

  logic              rank_we, rank_re;
  logic [ADDR_W-1:0] rank_wa, rank_ra, rank_wd, rank_rd;

  logic [CNT_W:0]    sum_a, sum_b, cnt_x;
  logic              fits, last_idx;
  logic [CNT_W-1:0]  idx_inc, run_dec;
  logic [LCP_W-1:0]  lcp_sat;
  logic [ADDR_W-1:0] idx_a;

  lcp_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_LEN)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_wa),
    .wdata_i (rank_wd),
    .re_i    (rank_re),
    .raddr_i (rank_ra),
    .rdata_o (rank_rd)
  );

  assign idx_a    = idx_q[ADDR_W-1:0];
  assign cnt_x    = {1'b0, count_i};
  assign sum_a    = {1'b0, idx_q} + {1'b0, run_q};
  assign sum_b    = (CNT_W+1)'(prev_q) + {1'b0, run_q};
  assign fits     = (sum_a < cnt_x) && (sum_b < cnt_x);
  assign idx_inc  = idx_q + CNT_W'(1);
  assign last_idx = (idx_inc == count_i);
  assign run_dec  = (run_q == '0) ? '0 : run_q - CNT_W'(1);
  assign lcp_sat  = (run_q > CNT_W'(LCP_MAX)) ? LCP_W'(LCP_MAX) : run_q[LCP_W-1:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    run_d   = run_q;
    pend_d  = pend_q;
    pidx_d  = pidx_q;
    r_d     = r_q;
    prev_d  = prev_q;
    req_o   = '0;
    rank_we = 1'b0;
    rank_wa = '0;
    rank_wd = '0;
    rank_re = 1'b0;
    rank_ra = idx_a;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CLEAR;
          idx_d   = '0;
        end
      end
      S_CLEAR: begin
        rank_we      = 1'b1;
        rank_wa      = idx_a;
        req_o.lcp_we = 1'b1;
        req_o.lcp_wa = idx_a;
        if (last_idx) begin
          state_d = S_RANK;
          idx_d   = '0;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_RANK: begin
        // issue suffix reads; in the next cycle scatter the index into the rank table
        pend_d = 1'b0;
        if (idx_q < count_i) begin
          req_o.sfx_re = 1'b1;
          req_o.sfx_ra = idx_a;
          pend_d       = 1'b1;
          pidx_d       = idx_a;
          idx_d        = idx_inc;
        end
        if (pend_q && (CNT_W'(rsp_i.sfx_rd) < count_i)) begin
          rank_we = 1'b1;
          rank_wa = rsp_i.sfx_rd;
          rank_wd = pidx_q;
        end
        if (!pend_q && idx_q == count_i) begin
          state_d = W_RANK;
          idx_d   = '0;
          run_d   = '0;
        end
      end
      W_RANK: begin
        rank_re = 1'b1;
        state_d = W_SFX;
      end
      W_SFX: begin
        r_d = rank_rd;
        if (rank_rd == '0) begin
          run_d   = run_dec;
          idx_d   = idx_inc;
          state_d = last_idx ? S_IDLE : W_RANK;
        end else begin
          req_o.sfx_re = 1'b1;
          req_o.sfx_ra = rank_rd - ADDR_W'(1);
          state_d      = W_PREV;
        end
      end
      W_PREV: begin
        prev_d  = rsp_i.sfx_rd;
        state_d = W_CMP;
      end
      W_CMP: begin
        if (fits) begin
          req_o.txt_re  = 1'b1;
          req_o.txt_ra0 = sum_a[ADDR_W-1:0];
          req_o.txt_ra1 = sum_b[ADDR_W-1:0];
          state_d       = W_CHK;
        end else begin
          req_o.lcp_we = 1'b1;
          req_o.lcp_wa = r_q - ADDR_W'(1);
          req_o.lcp_wd = lcp_sat;
          run_d        = run_dec;
          idx_d        = idx_inc;
          state_d      = last_idx ? S_IDLE : W_RANK;
        end
      end
      W_CHK: begin
        if (rsp_i.txt_rd0 == rsp_i.txt_rd1) begin
          run_d   = run_q + CNT_W'(1);
          state_d = W_CMP;
        end else begin
          req_o.lcp_we = 1'b1;
          req_o.lcp_wa = r_q - ADDR_W'(1);
          req_o.lcp_wd = lcp_sat;
          run_d        = run_dec;
          idx_d        = idx_inc;
          state_d      = last_idx ? S_IDLE : W_RANK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      run_q   <= '0;
      pend_q  <= 1'b0;
      pidx_q  <= '0;
      r_q     <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      run_q   <= run_d;
      pend_q  <= pend_d;
      pidx_q  <= pidx_d;
      r_q     <= r_d;
      prev_q  <= prev_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

### sv/lcp_array_from_suffix_array.sv
`default_nettype none

// Kasai LCP builder. Load beats (func 0) store one text symbol and one
// suffix-array entry each, one beat per cycle while the input is not
// stalled; the beat marked last (or the one that fills all 1024 slots)
// closes the set. The block then stalls its input while it builds: a clear
// sweep, an inverse-rank pass, and the walk over the n text positions, with
// a read and compare of the text copies per matched symbol (at most about 2n
// matches over the whole walk since the carried length drops by one per
// position). The walk is bounded by the single read port of the suffix and
// rank memories and the read/compare loop on the text copies. Drain beats
// (func 1) then return the n-1 LCP values in rank order at one beat per
// cycle while the output is not stalled, final_value marking the last; a
// drain with nothing to give returns none_left with zeroed fields. A load
// after a finished set starts a new one. Suffix entries not below n are
// ignored in the rank pass, repeats let the later rank win, and LCP values
// saturate at 1023.
module lcp_array_from_suffix_array (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            func_i,
  input  wire logic [lcp_pkg::SYMBOL_BITS-1:0] symbol_i,
  input  wire logic [lcp_pkg::SA_W-1:0]        suffix_start_i,
  input  wire logic                            last_element_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [lcp_pkg::LCP_W-1:0]       lcp_value_o,
  output logic      [lcp_pkg::ADDR_W-1:0]      rank_pos_o,
  output logic                                 final_value_o,
  output logic                                 none_left_o
);

  import lcp_pkg::*;

  // set bookkeeping
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] dp_q;
  logic              done_q;

  // drain lookup stage (lcp memory read in flight)
  logic              pend_q;
  logic              pend_none_q;
  logic [ADDR_W-1:0] pend_pos_q;
  logic              pend_fin_q;

  // output register
  logic              out_valid_q;
  logic [LCP_W-1:0]  out_lcp_q;
  logic [ADDR_W-1:0] out_pos_q;
  logic              out_fin_q;
  logic              out_none_q;

  logic              bld_busy;
  bld_req_t          bld_req;
  bld_rsp_t          bld_rsp;

  logic              out_free, accept, load_acc, drain_acc;
  logic [CNT_W-1:0]  base_cnt, new_cnt;
  logic              finish, avail, is_final, lcp_re;
  logic [LCP_W-1:0]  lcp_rd;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = bld_busy || (pend_q && !out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign load_acc   = accept && (func_i == FUNC_LOAD);
  assign drain_acc  = accept && (func_i == FUNC_DRAIN);

  // a load after a finished set restarts the count
  assign base_cnt = done_q ? '0 : cnt_q;
  assign new_cnt  = base_cnt + CNT_W'(1);
  assign finish   = last_element_i || (new_cnt == CNT_W'(MAX_LEN));

  assign avail    = done_q && (cnt_q >= CNT_W'(2)) &&
                    (CNT_W'(dp_q) < cnt_q - CNT_W'(1));
  assign is_final = (CNT_W'(dp_q) == cnt_q - CNT_W'(2));
  assign lcp_re   = drain_acc && avail;

  // two text copies give two compare reads per cycle
  lcp_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MAX_LEN)
  ) u_text_ram_a (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (base_cnt[ADDR_W-1:0]),
    .wdata_i (symbol_i),
    .re_i    (bld_req.txt_re),
    .raddr_i (bld_req.txt_ra0),
    .rdata_o (bld_rsp.txt_rd0)
  );

  lcp_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MAX_LEN)
  ) u_text_ram_b (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (base_cnt[ADDR_W-1:0]),
    .wdata_i (symbol_i),
    .re_i    (bld_req.txt_re),
    .raddr_i (bld_req.txt_ra1),
    .rdata_o (bld_rsp.txt_rd1)
  );

  lcp_ram #(
    .WIDTH (SA_W),
    .DEPTH (MAX_LEN)
  ) u_sfx_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (base_cnt[ADDR_W-1:0]),
    .wdata_i (suffix_start_i),
    .re_i    (bld_req.sfx_re),
    .raddr_i (bld_req.sfx_ra),
    .rdata_o (bld_rsp.sfx_rd)
  );

  lcp_ram #(
    .WIDTH (LCP_W),
    .DEPTH (MAX_LEN)
  ) u_lcp_ram (
    .clk_i   (clk_i),
    .we_i    (bld_req.lcp_we),
    .waddr_i (bld_req.lcp_wa),
    .wdata_i (bld_req.lcp_wd),
    .re_i    (lcp_re),
    .raddr_i (dp_q),
    .rdata_o (lcp_rd)
  );

  lcp_build u_build (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_acc && finish),
    .count_i (cnt_q),
    .busy_o  (bld_busy),
    .req_o   (bld_req),
    .rsp_i   (bld_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dp_q        <= '0;
      done_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_none_q <= 1'b0;
      pend_pos_q  <= '0;
      pend_fin_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_lcp_q   <= '0;
      out_pos_q   <= '0;
      out_fin_q   <= 1'b0;
      out_none_q  <= 1'b0;
    end else begin
      if (load_acc) begin
        cnt_q  <= new_cnt;
        done_q <= finish;
        dp_q   <= '0;
      end else if (lcp_re) begin
        dp_q <= dp_q + ADDR_W'(1);
      end

      // lookup stage: capture drain beat while the lcp read is in flight
      if (drain_acc) begin
        pend_q      <= 1'b1;
        pend_none_q <= !avail;
        pend_pos_q  <= avail ? dp_q : '0;
        pend_fin_q  <= avail && is_final;
      end else if (out_free) begin
        pend_q <= 1'b0;
      end

      // output register
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
        out_lcp_q   <= pend_none_q ? '0 : lcp_rd;
        out_pos_q   <= pend_pos_q;
        out_fin_q   <= pend_fin_q;
        out_none_q  <= pend_none_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lcp_value_o   = out_lcp_q;
  assign rank_pos_o    = out_pos_q;
  assign final_value_o = out_fin_q;
  assign none_left_o   = out_none_q;

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

// Regression bench for the Kasai LCP builder.
// An initial block queues every beat up front: a directed opening, then random
// sets of loads followed by drains. A clocked driver offers the beats with
// random gaps. A clocked monitor stalls at random and checks each result
// against a local model of the block.
module tb_top;
  import lcp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_BEATS  = 200;   // receiver hold-off, in cycles with a result waiting
  localparam int END_SLACK   = 60;

  // driver queue entries: a beat, a wait for all results, or a hold-off request
  typedef enum logic [1:0] {
    ENTRY_BEAT,
    ENTRY_SYNC,
    ENTRY_HOLD
  } entry_kind_e;

  typedef struct {
    entry_kind_e            kind;
    func_e                  func;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [SA_W-1:0]        sfx;
    logic                   last;
  } stim_entry_t;

  typedef struct {
    logic [LCP_W-1:0]  lcp;
    logic [ADDR_W-1:0] rank;
    logic              fin;
    logic              none;
  } lcp_result_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   func_i         = FUNC_LOAD;
  logic [SYMBOL_BITS-1:0] symbol_i       = '0;
  logic [SA_W-1:0]        suffix_start_i = '0;
  logic                   last_element_i = 1'b0;
  logic                   out_stall_i    = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [LCP_W-1:0]       lcp_value_o;
  logic [ADDR_W-1:0]      rank_pos_o;
  logic                   final_value_o;
  logic                   none_left_o;

  lcp_array_from_suffix_array u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .symbol_i       (symbol_i),
    .suffix_start_i (suffix_start_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lcp_value_o    (lcp_value_o),
    .rank_pos_o     (rank_pos_o),
    .final_value_o  (final_value_o),
    .none_left_o    (none_left_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model of the block: loaded text and suffix array, inverse ranks, LCP table
  // ---------------------------------------------------------------------------
  logic [SYMBOL_BITS-1:0] text_mem [MAX_LEN];
  logic [SA_W-1:0]        sfx_mem  [MAX_LEN];
  logic [SA_W-1:0]        rank_mem [MAX_LEN];
  logic [LCP_W-1:0]       lcp_mem  [MAX_LEN];
  int                     text_len;
  int                     drain_ix;
  bit                     set_closed;

  lcp_result_t lcp_due[$];     // drain results still owed by the block
  stim_entry_t pending[$];     // beats not yet offered

  int errors, n_sets, n_loads, n_drains, n_empty, n_sat;
  int cycles, gap_left, hold_asks, hold_done, hold_left;
  bit steady;

  // Kasai walk over the loaded set; the carried match length drops by one
  // per text position and is never clipped, only the stored value is.
  function automatic void kasai_build();
    int n, run, r, prev;
    n   = text_len;
    run = 0;
    for (int i = 0; i < n; i++) begin
      rank_mem[i] = '0;
      lcp_mem[i]  = '0;
    end
    // out-of-range entries are skipped; with repeats the later rank wins
    for (int i = 0; i < n; i++)
      if (int'(sfx_mem[i]) < n) rank_mem[sfx_mem[i]] = i[SA_W-1:0];
    for (int i = 0; i < n; i++) begin
      r   = int'(rank_mem[i]);
      run = (run > 0) ? run - 1 : 0;
      if (r != 0 && r < n) begin
        prev = int'(sfx_mem[r-1]);
        while (i + run < n && prev + run < n && text_mem[i+run] == text_mem[prev+run])
          run++;
        lcp_mem[r-1] = (run > LCP_MAX) ? LCP_MAX[LCP_W-1:0] : run[LCP_W-1:0];
      end
    end
  endfunction

  // One accepted beat: loads update the set, drains owe exactly one result.
  function automatic void track_beat(func_e f, logic [SYMBOL_BITS-1:0] s,
                                     logic [SA_W-1:0] a, logic last);
    lcp_result_t res;
    if (f == FUNC_LOAD) begin
      n_loads++;
      if (set_closed) begin
        text_len   = 0;
        drain_ix   = 0;
        set_closed = 1'b0;
      end
      if (text_len < MAX_LEN) begin
        text_mem[text_len] = s;
        sfx_mem[text_len]  = a;
        text_len++;
      end
      // a full text closes itself even without the mark
      if (last || text_len >= MAX_LEN) begin
        set_closed = 1'b1;
        drain_ix   = 0;
        n_sets++;
        kasai_build();
      end
    end else begin
      n_drains++;
      if (set_closed && text_len >= 2 && drain_ix < text_len - 1) begin
        res.lcp  = lcp_mem[drain_ix];
        res.rank = drain_ix[ADDR_W-1:0];
        res.fin  = (drain_ix == text_len - 2);
        res.none = 1'b0;
        if (res.lcp == LCP_MAX) n_sat++;
        drain_ix++;
      end else begin
        res = '{lcp: '0, rank: '0, fin: 1'b0, none: 1'b1};
        n_empty++;
      end
      lcp_due.insert(lcp_due.size(), res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int                     stim_beats;
  logic [SYMBOL_BITS-1:0] set_txt [MAX_LEN];
  int                     set_sa  [MAX_LEN];

  function automatic void queue_entry(stim_entry_t e);
    pending.insert(pending.size(), e);
  endfunction

  function automatic void push_load(logic [SYMBOL_BITS-1:0] s, logic [SA_W-1:0] a,
                                    logic last);
    queue_entry('{kind: ENTRY_BEAT, func: FUNC_LOAD, symbol: s, sfx: a, last: last});
    stim_beats++;
  endfunction

  function automatic void push_drain();
    queue_entry('{kind: ENTRY_BEAT, func: FUNC_DRAIN,
                  symbol: SYMBOL_BITS'($urandom_range(0, 255)),
                  sfx: SA_W'($urandom_range(0, 1023)), last: 1'($urandom_range(0, 1))});
    stim_beats++;
  endfunction

  function automatic void push_marker(entry_kind_e k);
    queue_entry('{kind: k, func: FUNC_LOAD, symbol: '0, sfx: '0, last: 1'b0});
  endfunction

  // lexicographic order of two suffixes of set_txt; a proper prefix sorts first
  function automatic bit sfx_less(int a, int b, int n);
    while (a < n && b < n) begin
      if (set_txt[a] != set_txt[b]) return set_txt[a] < set_txt[b];
      a++;
      b++;
    end
    return a == n;
  endfunction

  // One text of length n with its suffix array, optionally damaged, then drains.
  // flaw: 0 sorted, 1 random permutation, 2 entries out of range, 3 repeats.
  function automatic void add_set(int n, int flaw, bit with_hold);
    int style, alpha, base, period, key, j, tmp, mid_at, drains;
    style  = $urandom_range(0, 2);
    alpha  = $urandom_range(1, 4);
    base   = $urandom_range(0, 252);
    period = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      case (style)
        0:       set_txt[i] = SYMBOL_BITS'($urandom_range(0, 255));
        1:       set_txt[i] = SYMBOL_BITS'(base + $urandom_range(0, alpha - 1));
        default: set_txt[i] = (i < period) ? SYMBOL_BITS'($urandom_range(0, 255))
                                           : set_txt[i-period];
      endcase
    end
    // insertion sort gives the true suffix array
    for (int i = 0; i < n; i++) set_sa[i] = i;
    for (int i = 1; i < n; i++) begin
      key = set_sa[i];
      j   = i - 1;
      while (j >= 0 && sfx_less(key, set_sa[j], n)) begin
        set_sa[j+1] = set_sa[j];
        j--;
      end
      set_sa[j+1] = key;
    end
    case (flaw)
      1: for (int i = n - 1; i > 0; i--) begin
        j         = $urandom_range(0, i);
        tmp       = set_sa[i];
        set_sa[i] = set_sa[j];
        set_sa[j] = tmp;
      end
      2: repeat ($urandom_range(1, 3)) set_sa[$urandom_range(0, n - 1)] = $urandom_range(n, 1023);
      3: repeat ($urandom_range(1, 3)) set_sa[$urandom_range(0, n - 1)] =
           set_sa[$urandom_range(0, n - 1)];
      default: ;
    endcase
    // now and then a drain lands while the set is still loading
    mid_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == mid_at) push_drain();
      push_load(set_txt[i], set_sa[i][SA_W-1:0], i == n - 1);
    end
    if (with_hold) push_marker(ENTRY_HOLD);
    // mostly a full drain plus up to two empty ones; sometimes cut short
    if ($urandom_range(0, 6) == 0) drains = $urandom_range(0, n - 1);
    else drains = n - 1 + $urandom_range(0, 2);
    repeat (drains) push_drain();
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: beats change only after acceptance; markers are handled between beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    stim_entry_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      hold_asks  <= 0;
      gap_left    = 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        track_beat(func_e'(func_i), symbol_i, suffix_start_i, last_element_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending[0].kind == ENTRY_SYNC) begin
          // sender pause: nothing more until every owed result is back
          in_valid_i <= 1'b0;
          if (lcp_due.size() == 0) void'(pending.pop_front());
        end else if (pending[0].kind == ENTRY_HOLD) begin
          in_valid_i <= 1'b0;
          hold_asks  <= hold_asks + 1;
          void'(pending.pop_front());
        end else begin
          nxt             = pending.pop_front();
          in_valid_i     <= 1'b1;
          func_i         <= nxt.func;
          symbol_i       <= nxt.symbol;
          suffix_start_i <= nxt.sfx;
          last_element_i <= nxt.last;
          gap_left        = pick_gap();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random runs, plus a long hold-off on request that only
  // counts down while a result sits at the output, so the block backs up.
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_done   <= 0;
      hold_left    = 0;
      stall_left   = 0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      if (out_valid_o) hold_left--;
    end else if (hold_done < hold_asks) begin
      out_stall_i <= 1'b1;
      hold_done   <= hold_done + 1;
      hold_left    = HOLD_BEATS;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left   = (r < 93) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check, oldest owed result first
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lcp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lcp_due.size() == 0) begin
        $error("result with none owed: lcp_value=%0d rank_pos=%0d final_value=%0b none_left=%0b",
               lcp_value_o, rank_pos_o, final_value_o, none_left_o);
        errors++;
      end else begin
        want = lcp_due.pop_front();
        if (lcp_value_o !== want.lcp) begin
          $error("lcp_value: expected %0d, got %0d", want.lcp, lcp_value_o);
          errors++;
        end
        if (rank_pos_o !== want.rank) begin
          $error("rank_pos: expected %0d, got %0d", want.rank, rank_pos_o);
          errors++;
        end
        if (final_value_o !== want.fin) begin
          $error("final_value: expected %0b, got %0b", want.fin, final_value_o);
          errors++;
        end
        if (none_left_o !== want.none) begin
          $error("none_left: expected %0b, got %0b", want.none, none_left_o);
          errors++;
        end
      end
    end
  end

  // cycle budget, and the occasional stretch with no idling on either side
  always @(posedge clk_i) begin
    cycles++;
    if (cycles % 1500 == 0) steady <= ($urandom_range(0, 3) == 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("lcp_array_from_suffix_array regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int set_no, n, r;

    // directed: drain with nothing loaded
    push_drain();
    // one-element text: closes, but drains find nothing
    push_load(8'h00, 10'd0, 1'b1);
    push_drain();
    // two equal top symbols: one value of 1, flagged final, then exhausted
    push_load(8'hFF, 10'd1, 1'b0);
    push_load(8'hFF, 10'd0, 1'b1);
    push_drain();
    push_drain();
    // suffix entry out of range, with a drain while the set is loading
    push_load(8'h61, 10'd1023, 1'b0);
    push_drain();
    push_load(8'h62, 10'd0, 1'b0);
    push_load(8'h61, 10'd1, 1'b1);
    push_drain();
    push_drain();
    // repeated suffix entries: later rank wins, unreached entries stay zero
    push_load(8'h41, 10'd2, 1'b0);
    push_load(8'h41, 10'd2, 1'b0);
    push_load(8'h41, 10'd0, 1'b1);
    repeat (3) push_drain();
    push_marker(ENTRY_SYNC);

    // random sets, mostly short true suffix arrays; the full text always goes in
    set_no = 0;
    while (stim_beats < 1800 || set_no <= 12) begin
      if (set_no == 4 || set_no == 30) begin
        add_set(60, 0, 1'b1);
      end else if (set_no == 12) begin
        // full 1024-symbol text with no last mark; suffix 0 at ranks 0 and 1
        // makes position 0 match itself across the whole text, so the first
        // value saturates. Only part of it is drained before the next set.
        for (int i = 0; i < MAX_LEN; i++)
          push_load(SYMBOL_BITS'($urandom_range(0, 255)),
                    (i < 2) ? 10'd0 : 10'($urandom_range(1, 1023)), 1'b0);
        repeat ($urandom_range(30, 60)) push_drain();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) n = 1;
        else if (r < 80) n = $urandom_range(2, 20);
        else if (r < 96) n = $urandom_range(21, 80);
        else n = $urandom_range(81, 200);
        r = $urandom_range(0, 99);
        add_set(n, (r < 78) ? 0 : (r < 86) ? 1 : (r < 93) ? 2 : 3, 1'b0);
      end
      if (set_no % 8 == 7) push_marker(ENTRY_SYNC);
      set_no++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (lcp_due.size() != 0) @(posedge clk_i);
    repeat (END_SLACK) @(posedge clk_i);

    $display("covered %0d sets: %0d loads, %0d drains (%0d empty, %0d saturated values)",
             n_sets, n_loads, n_drains, n_empty, n_sat);
    $display("receiver hold-offs: %0d, cycles: %0d", hold_done, cycles);
    if (errors == 0) begin
      $display("lcp_array_from_suffix_array regression: pass");
    end else begin
      $display("lcp_array_from_suffix_array regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/lcp_pkg.sv
sv/lcp_ram.sv
sv/lcp_build.sv
sv/lcp_array_from_suffix_array.sv
dv/tb_top.sv
